// ----- hw/rtl/i2cm_seq_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq_pkg
// Shared types and codes for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_seq_pkg;

   // command kinds carried in the request tuser
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned STEP_W     = 5;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd5;

   // phases per command
   localparam logic [STEP_W-1:0] START_PHASES = 5'd3;
   localparam logic [STEP_W-1:0] STOP_PHASES  = 5'd3;
   localparam logic [STEP_W-1:0] WRITE_PHASES = 5'd27;
   localparam logic [STEP_W-1:0] READ_PHASES  = 5'd19;

   // write: 8 bits of 3 phases, then ack release / SCL high / SCL low
   localparam logic [STEP_W-1:0] WR_ACK_REL  = 5'd24;
   localparam logic [STEP_W-1:0] WR_ACK_HIGH = 5'd25;
   // read: 8 bits of 2 phases, then ack drive / SCL high / SCL low
   localparam logic [STEP_W-1:0] RD_ACK_DRV  = 5'd16;
   localparam logic [STEP_W-1:0] RD_ACK_HIGH = 5'd17;

   // position inside one write bit
   localparam logic [1:0] SUB_DATA = 2'd0;
   localparam logic [1:0] SUB_HIGH = 2'd1;
   localparam logic [1:0] SUB_LOW  = 2'd2;

   typedef enum logic [4:0] {
      OP_IDLE  = 5'b00001,
      OP_START = 5'b00010,
      OP_STOP  = 5'b00100,
      OP_WRITE = 5'b01000,
      OP_READ  = 5'b10000
   } op_type;

   // response word, lowest field last
   typedef struct packed {
      logic [1:0] pad;
      logic       rejected;
      logic       ack_seen;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_level;
      logic       scl_level;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- hw/rtl/i2c_master_byte_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// I2C master that walks the SCL/SDA waveform one phase per phase_ticks ticks.
// ----------------------------------------------------------------------------
// Every request transaction (a tick or a start/stop/write/read command) gives
// exactly one response transaction with the line drive levels, busy/done
// status, last read byte, last write ack and a rejected flag. A command that
// arrives while a sequence runs is rejected and does not advance time; unused
// kind codes change nothing but still get a response. The sequencer state is
// updated in the cycle a request is accepted and the response lands in an
// output register backed by a one-entry skid register, so one request is
// taken per clock, sustained, as long as the response side keeps up; a
// stalled response side costs one extra request before req_tready drops.
// phase_ticks is written through the csr port (always ready) and must only be
// changed while no sequence is running. Zero is treated as one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_sequencer
   import i2cm_seq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // data_byte[7:0], ack_to_send, sda_sample
   input  wire logic [2:0]            req_tuser,  // kind
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // scl_level, sda_level, busy_res, done_res, read_data[7:0], ack_seen, rejected
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [TICK_W-1:0]     csr_data
);

   // ---------------------------------------------------------------- state
   op_type              op_ff, op_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          sub_ff, sub_in;      // step mod 3 during a write
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [7:0]          shift_ff, shift_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic                ack_cap_ff, ack_cap_in;
   logic                ack_plan_ff, ack_plan_in;
   logic [7:0]          rd_hold_ff, rd_hold_in;
   logic [TICK_W-1:0]   phase_ticks_ff;

   // output register and skid
   logic                out_valid_ff;
   rsp_word_type        out_word_ff;
   logic                skid_valid_ff;
   rsp_word_type        skid_word_ff;

   logic                req_accept;
   logic                rsp_pop;
   rsp_word_type        new_word;

   logic [2:0]          kind;
   logic [7:0]          data_byte;
   logic                ack_to_send;
   logic                sda_sample;

   assign kind        = req_tuser;
   assign data_byte   = req_tdata[7:0];
   assign ack_to_send = req_tdata[8];
   assign sda_sample  = req_tdata[9];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   // ----------------------------------------------------- next-state logic
   always_comb begin
      logic [TICK_W-1:0] limit;
      logic [TICK_W-1:0] tick_inc;
      logic [STEP_W-1:0] total;
      logic [STEP_W-1:0] nstep;
      logic [1:0]        nsub;
      logic              phase_end;
      logic              done;
      logic              rej;

      op_in       = op_ff;
      step_in     = step_ff;
      sub_in      = sub_ff;
      tick_in     = tick_ff;
      shift_in    = shift_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      ack_cap_in  = ack_cap_ff;
      ack_plan_in = ack_plan_ff;
      rd_hold_in  = rd_hold_ff;
      done        = 1'b0;
      rej         = 1'b0;

      limit     = (phase_ticks_ff == '0) ? TICK_W'(1) : phase_ticks_ff;
      tick_inc  = tick_ff + TICK_W'(1);
      phase_end = (tick_inc >= limit);
      nstep     = step_ff + STEP_W'(1);
      nsub      = (sub_ff == SUB_LOW) ? SUB_DATA : sub_ff + 2'd1;

      unique case (op_ff)
         OP_START: total = START_PHASES;
         OP_STOP:  total = STOP_PHASES;
         OP_WRITE: total = WRITE_PHASES;
         OP_READ:  total = READ_PHASES;
         default:  total = '0;
      endcase

      if (kind == KIND_TICK) begin
         if (op_ff != OP_IDLE) begin
            tick_in = tick_inc;
            if (phase_end) begin
               tick_in = '0;
               // sample / shift at the end of the current phase
               if (op_ff == OP_WRITE) begin
                  if (step_ff < WR_ACK_REL && sub_ff == SUB_LOW) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                  end else if (step_ff == WR_ACK_HIGH) begin
                     ack_cap_in = sda_sample;
                  end
               end else if (op_ff == OP_READ) begin
                  if (step_ff < RD_ACK_DRV && !step_ff[0]) begin
                     shift_in = {shift_ff[6:0], sda_sample};
                  end
               end
               step_in = nstep;
               sub_in  = nsub;
               if (nstep >= total) begin
                  if (op_ff == OP_READ) begin
                     rd_hold_in = shift_in;
                  end
                  op_in   = OP_IDLE;
                  step_in = '0;
                  sub_in  = SUB_DATA;
                  done    = 1'b1;
               end else begin
                  // line levels of the next phase
                  unique case (op_ff)
                     OP_START: begin
                        if (nstep == STEP_W'(1)) sda_in = 1'b0;
                        else scl_in = 1'b0;
                     end
                     OP_STOP: begin
                        if (nstep == STEP_W'(1)) scl_in = 1'b1;
                        else sda_in = 1'b1;
                     end
                     OP_WRITE: begin
                        if (nstep < WR_ACK_REL) begin
                           unique case (nsub)
                              SUB_DATA: sda_in = shift_in[7];
                              SUB_HIGH: scl_in = 1'b1;
                              default:  scl_in = 1'b0;
                           endcase
                        end else if (nstep == WR_ACK_REL) begin
                           sda_in = 1'b1;
                        end else if (nstep == WR_ACK_HIGH) begin
                           scl_in = 1'b1;
                        end else begin
                           scl_in = 1'b0;
                        end
                     end
                     OP_READ: begin
                        if (nstep < RD_ACK_DRV) begin
                           scl_in = !nstep[0];
                        end else if (nstep == RD_ACK_DRV) begin
                           sda_in = !ack_plan_ff;
                        end else if (nstep == RD_ACK_HIGH) begin
                           scl_in = 1'b1;
                        end else begin
                           scl_in = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end else if (kind == KIND_START || kind == KIND_STOP ||
                   kind == KIND_WRITE || kind == KIND_READ) begin
         if (op_ff != OP_IDLE) begin
            rej = 1'b1;
         end else begin
            step_in = '0;
            sub_in  = SUB_DATA;
            tick_in = '0;
            unique case (kind)
               KIND_START: begin
                  op_in  = OP_START;
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end
               KIND_STOP: begin
                  op_in  = OP_STOP;
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end
               KIND_WRITE: begin
                  op_in    = OP_WRITE;
                  shift_in = data_byte;
                  sda_in   = data_byte[7];
               end
               default: begin
                  op_in       = OP_READ;
                  shift_in    = '0;
                  ack_plan_in = ack_to_send;
                  sda_in      = 1'b1;
                  scl_in      = 1'b1;
               end
            endcase
         end
      end

      new_word.pad       = '0;
      new_word.rejected  = rej;
      new_word.ack_seen  = ack_cap_in;
      new_word.read_data = rd_hold_in;
      new_word.done_res  = done;
      new_word.busy_res  = (op_in != OP_IDLE);
      new_word.sda_level = sda_in;
      new_word.scl_level = scl_in;
   end

   // ------------------------------------------------------- state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= OP_IDLE;
         step_ff     <= '0;
         sub_ff      <= SUB_DATA;
         tick_ff     <= '0;
         shift_ff    <= '0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         ack_cap_ff  <= 1'b0;
         ack_plan_ff <= 1'b0;
         rd_hold_ff  <= '0;
      end else if (req_accept) begin
         op_ff       <= op_in;
         step_ff     <= step_in;
         sub_ff      <= sub_in;
         tick_ff     <= tick_in;
         shift_ff    <= shift_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         ack_cap_ff  <= ack_cap_in;
         ack_plan_ff <= ack_plan_in;
         rd_hold_ff  <= rd_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         phase_ticks_ff <= csr_data;
      end
   end

   // ----------------------------------------------- output register + skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_pop) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : new_word;
      end else if (req_accept) begin
         skid_word_ff <= new_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_word_ff);

`ifndef SYNTHESIS
   // an accepted command on an idle sequencer starts a sequence
   a_cmd_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op_ff == OP_IDLE &&
       (kind == KIND_START || kind == KIND_STOP ||
        kind == KIND_WRITE || kind == KIND_READ)) |=> (op_ff != OP_IDLE))
      else $error("command on idle sequencer did not start a sequence");

   // step index stays inside the running command's phase list
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (op_ff == OP_IDLE && step_ff == '0) ||
      (op_ff == OP_START && step_ff < START_PHASES) ||
      (op_ff == OP_STOP && step_ff < STOP_PHASES) ||
      (op_ff == OP_WRITE && step_ff < WRITE_PHASES) ||
      (op_ff == OP_READ && step_ff < READ_PHASES))
      else $error("step index out of range");

   // skid entry only exists behind a full output register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a response while output register is empty");

   // a request taken while output stalls must land in the skid
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("response lost under back-pressure");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_i2c_master_byte_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_sequencer
// Self-checking bench for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
// A line-level predictor tracks the sequencer state for every accepted request
// transaction and queues the response it should produce. Each response is
// checked field by field against the oldest queued one. Stimulus is random
// I2C-like transactions (start, address write, data writes/reads, stop)
// with ticks between them, mixed with short directed runs and with
// rejected and unused commands. It runs under several phase lengths,
// including zero and a long one.
// ----------------------------------------------------------------------------

import i2cm_seq_pkg::*;

class seq_line_predictor;
   int unsigned  mismatch_count;
   int unsigned  resp_index;
   rsp_word_type expected_levels[$];

   logic [TICK_W-1:0] phase_ticks;
   op_type            op;
   logic [STEP_W-1:0] step;
   logic [TICK_W-1:0] tick_cnt;
   logic [7:0]        shifter;
   logic              scl_drv;
   logic              sda_drv;
   logic              ack_cap;
   logic              ack_plan;
   logic [7:0]        read_hold;

   function new();
      mismatch_count = 0;
      resp_index     = 0;
      phase_ticks    = PHASE_TICKS_RESET;
      op             = OP_IDLE;
      step           = '0;
      tick_cnt       = '0;
      shifter        = '0;
      scl_drv        = 1'b1;
      sda_drv        = 1'b1;
      ack_cap        = 1'b0;
      ack_plan       = 1'b0;
      read_hold      = '0;
   endfunction

   function void set_phase_ticks(logic [TICK_W-1:0] value);
      phase_ticks = value;
   endfunction

   function bit is_busy();
      return op != OP_IDLE;
   endfunction

   function int pending();
      return expected_levels.size();
   endfunction

   function logic [STEP_W-1:0] phase_count();
      case (op)
         OP_START: return START_PHASES;
         OP_STOP:  return STOP_PHASES;
         OP_WRITE: return WRITE_PHASES;
         OP_READ:  return READ_PHASES;
         default:  return '0;
      endcase
   endfunction

   // line levels applied when a phase begins
   function void open_phase();
      case (op)
         OP_START: begin
            if (step == 0) begin
               scl_drv = 1'b1;
               sda_drv = 1'b1;
            end else if (step == 1) sda_drv = 1'b0;
            else scl_drv = 1'b0;
         end
         OP_STOP: begin
            if (step == 0) begin
               scl_drv = 1'b0;
               sda_drv = 1'b0;
            end else if (step == 1) scl_drv = 1'b1;
            else sda_drv = 1'b1;
         end
         OP_WRITE: begin
            if (step < WR_ACK_REL) begin
               if (step % 3 == SUB_DATA) sda_drv = shifter[7];
               else if (step % 3 == SUB_HIGH) scl_drv = 1'b1;
               else scl_drv = 1'b0;
            end else if (step == WR_ACK_REL) sda_drv = 1'b1;
            else if (step == WR_ACK_HIGH) scl_drv = 1'b1;
            else scl_drv = 1'b0;
         end
         OP_READ: begin
            if (step < RD_ACK_DRV) begin
               if (!step[0]) begin
                  if (step == 0) sda_drv = 1'b1;
                  scl_drv = 1'b1;
               end else scl_drv = 1'b0;
            end else if (step == RD_ACK_DRV) sda_drv = !ack_plan;
            else if (step == RD_ACK_HIGH) scl_drv = 1'b1;
            else scl_drv = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // sampling and shifting done as a phase ends
   function void close_phase(logic line_sda);
      if (op == OP_WRITE) begin
         if (step < WR_ACK_REL && step % 3 == SUB_LOW) shifter = {shifter[6:0], 1'b0};
         else if (step == WR_ACK_HIGH) ack_cap = line_sda;
      end else if (op == OP_READ) begin
         if (step < RD_ACK_DRV && !step[0]) shifter = {shifter[6:0], line_sda};
      end
   endfunction

   function void take_request(logic [2:0] kind, logic [7:0] data, logic ack_in,
                              logic line_sda);
      rsp_word_type      want;
      logic [TICK_W-1:0] limit;
      logic              done;
      logic              rej;
      done = 1'b0;
      rej  = 1'b0;
      if (kind == KIND_TICK) begin
         if (op != OP_IDLE) begin
            limit    = (phase_ticks == 0) ? 16'd1 : phase_ticks;
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= limit) begin
               tick_cnt = '0;
               close_phase(line_sda);
               step = step + 1'b1;
               if (step >= phase_count()) begin
                  if (op == OP_READ) read_hold = shifter;
                  op   = OP_IDLE;
                  step = '0;
                  done = 1'b1;
               end else open_phase();
            end
         end
      end else if (kind <= KIND_READ) begin
         if (op != OP_IDLE) rej = 1'b1;
         else begin
            case (kind)
               KIND_START: op = OP_START;
               KIND_STOP:  op = OP_STOP;
               KIND_WRITE: op = OP_WRITE;
               default:    op = OP_READ;
            endcase
            step     = '0;
            tick_cnt = '0;
            if (kind == KIND_WRITE) shifter = data;
            else if (kind == KIND_READ) begin
               shifter  = '0;
               ack_plan = ack_in;
            end
            open_phase();
         end
      end
      want           = '0;
      want.scl_level = scl_drv;
      want.sda_level = sda_drv;
      want.busy_res  = (op != OP_IDLE);
      want.done_res  = done;
      want.read_data = read_hold;
      want.ack_seen  = ack_cap;
      want.rejected  = rej;
      expected_levels.push_back(want);
   endfunction

   task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report($sformatf("response %0d %s got %0h want %0h", resp_index, name, got, want));
   endtask

   task check_levels(rsp_word_type got);
      rsp_word_type want;
      if (expected_levels.size() == 0) begin
         report($sformatf("response %0h with nothing outstanding", got));
      end else begin
         want = expected_levels.pop_front();
         compare_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
         compare_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
         compare_field("busy_res",  8'(got.busy_res),  8'(want.busy_res));
         compare_field("done_res",  8'(got.done_res),  8'(want.done_res));
         compare_field("read_data", got.read_data, want.read_data);
         compare_field("ack_seen",  8'(got.ack_seen),  8'(want.ack_seen));
         compare_field("rejected",  8'(got.rejected),  8'(want.rejected));
         resp_index++;
      end
   endtask

   task flush_leftovers();
      if (expected_levels.size() != 0)
         report($sformatf("%0d responses never arrived", expected_levels.size()));
   endtask
endclass

module tb_i2c_master_byte_sequencer;

   // kind codes the block ignores outright
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   // cycles without any transaction before the run is declared hung
   localparam int unsigned STALL_LIMIT  = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [2:0]            req_tuser  = KIND_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [TICK_W-1:0]     csr_data   = '0;

   seq_line_predictor lines = new();

   int unsigned burst_left   = 0;   // request transactions left in this burst
   int unsigned quiet_cycles = 0;   // watchdog count
   int unsigned cyc          = 0;
   logic [15:0] stall_pat    = 16'hFFFF;
   logic [2:0]  plan_q[$];          // commands of the I2C transaction in flight

   i2c_master_byte_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: ready follows a repeating 16-bit pattern that is redrawn
   // for each window. A third of the windows never stall; the rest always keep
   // some ready cycles so the pipe drains.
   always @(negedge clock) begin
      cyc = cyc + 1;
      if (cyc % 128 == 0)
         stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                 : 16'($urandom() | 32'h0101);
      rsp_tready = stall_pat[cyc[3:0]];
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) lines.check_levels(rsp_tdata);
   end

   // watchdog: nothing moved on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transaction. The sender runs in bursts; between bursts valid
   // drops for a short random gap. Called and returns at a falling edge.
   task automatic drive_req(input logic [2:0] kind, input logic [7:0] data,
                            input logic ack, input logic line_sda);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {6'd0, line_sda, ack, data};
      do @(posedge clock); while (!req_tready);
      lines.take_request(kind, data, ack, line_sda);
      @(negedge clock);
   endtask

   task automatic drive_tick();
      drive_req(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // hold off the sender until every predicted response has come back
   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (lines.pending() != 0) @(negedge clock);
   endtask

   // tick until the running command completes
   task automatic finish_sequence();
      while (lines.is_busy()) drive_tick();
   endtask

   // phase length changes only with the sequencer idle and the pipe empty
   task automatic write_phase_ticks(input logic [TICK_W-1:0] value);
      finish_sequence();
      drain_responses();
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      lines.set_phase_ticks(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random stimulus. While idle, mostly the next command of a planned I2C
   // transaction; while busy, mostly ticks with the odd command that must be
   // rejected and odd unused codes that must leave everything alone.
   task automatic random_item();
      logic [2:0]  kind;
      logic [7:0]  data;
      int unsigned roll;
      int unsigned n_data;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0:       data = 8'h00;
         1:       data = 8'hFF;
         default: data = 8'($urandom_range(0, 255));
      endcase
      if (lines.is_busy()) begin
         if (roll < 4) kind = 3'($urandom_range(KIND_START, KIND_READ));
         else if (roll < 8) kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         else kind = KIND_TICK;
      end else if (roll < 5) begin
         kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end else if (roll < 12) begin
         kind = KIND_TICK;
      end else begin
         if (plan_q.size() == 0) begin
            if ($urandom_range(0, 5) == 0) begin
               plan_q.push_back(3'($urandom_range(KIND_START, KIND_READ)));
            end else begin
               // start, address byte, a few data bytes, stop
               plan_q.push_back(KIND_START);
               plan_q.push_back(KIND_WRITE);
               n_data = $urandom_range(1, 3);
               repeat (n_data)
                  plan_q.push_back($urandom_range(0, 1) ? KIND_WRITE : KIND_READ);
               plan_q.push_back(KIND_STOP);
            end
         end
         kind = plan_q.pop_front();
      end
      drive_req(kind, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset phase length
      repeat (300) random_item();

      // zero phase length behaves as one tick per phase
      write_phase_ticks(16'd0);
      drive_tick();                                   // tick while idle
      drive_req(KIND_SPARE_LO, 8'hFF, 1'b1, 1'b1);    // unused codes while idle
      drive_req(KIND_SPARE_LO + 3'd1, 8'h00, 1'b0, 1'b0);
      drive_req(KIND_SPARE_HI, 8'hFF, 1'b1, 1'b0);
      drive_req(KIND_START, 8'hFF, 1'b1, 1'b1);
      drive_req(KIND_STOP, 8'h00, 1'b0, 1'b0);        // rejected while busy
      drive_req(KIND_SPARE_HI, 8'h00, 1'b0, 1'b1);    // no time passes
      repeat (3) drive_tick();
      drive_req(KIND_STOP, 8'h00, 1'b0, 1'b0);
      drive_req(KIND_READ, 8'h00, 1'b1, 1'b0);        // rejected while busy
      repeat (3) drive_tick();
      drive_tick();                                   // lines hold after stop
      repeat (300) random_item();

      // one tick per phase; pause once mid-run until the pipe is empty
      write_phase_ticks(16'd1);
      repeat (200) random_item();
      drain_responses();
      repeat (200) random_item();

      write_phase_ticks(16'd3);
      repeat (300) random_item();

      // long phase: a single start, with a rejected command and an
      // ignored code thrown in while it runs
      write_phase_ticks(16'd40);
      drive_req(KIND_START, 8'h5A, 1'b0, 1'b1);
      drive_req(KIND_WRITE, 8'hA5, 1'b1, 1'b0);
      drive_req(KIND_SPARE_LO, 8'h00, 1'b0, 1'b1);
      finish_sequence();

      write_phase_ticks(16'($urandom_range(2, 9)));
      repeat (300) random_item();

      finish_sequence();
      drain_responses();
      repeat (8) @(negedge clock);
      lines.flush_leftovers();
      if (lines.mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
